[rtl/ucrr_pkg.sv]
// Package for the endpoint-zero control request responder.
// Holds the word types, request codes, the descriptor table and its directory.
// No dependencies.
`timescale 1ns / 1ps

package ucrr_pkg;

    // Configuration of the device.
    localparam int EP0_PACKET_BYTES = 64;
    localparam int NUM_ENDPOINTS    = 4;
    localparam int FLUSH_TICKS      = 5;
    localparam int ROM_BYTES        = 256;

    localparam int MAX_RESULTS = 40;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int PKT_W       = $clog2(EP0_PACKET_BYTES);
    localparam int DIR_COUNT   = 9;
    localparam int DIR_IW      = $clog2(DIR_COUNT);
    localparam int DESC_BYTES  = 151;

    // Event codes on the input channel.
    localparam logic [1:0] OP_SETUP     = 2'd0;
    localparam logic [1:0] OP_BUS_RESET = 2'd1;
    localparam logic [1:0] OP_SOF       = 2'd2;
    localparam logic [1:0] OP_TX_BYTE   = 2'd3;

    // Standard request codes and selectors.
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
    localparam logic [15:0] FEAT_DEBUG_MODE   = 16'd6;

    localparam logic [7:0] RT_STD_DEVICE_OUT = 8'h00;
    localparam logic [7:0] RT_STD_ENDPT_OUT  = 8'h02;
    localparam logic [7:0] RT_STD_DEVICE_IN  = 8'h80;
    localparam logic [7:0] RT_STD_ENDPT_IN   = 8'h82;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_ZLP  = 2'd1,
        K_STALL = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_DATA,
        S_ZLP,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  request_type;
        logic [7:0]  request;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [7:0]  configuration;
        logic [6:0]  device_address;
        logic        led;
        logic        flush;
    } t_out_item;

    typedef struct packed {
        logic [15:0] sel_value;
        logic [15:0] sel_index;
        logic [7:0]  offset;
        logic [7:0]  size;
    } t_dir_entry;

    localparam logic [7:0] EP0_B = 8'(EP0_PACKET_BYTES);

    localparam logic [7:0] DESC_ROM [0:DESC_BYTES-1] = '{
        // device descriptor
        8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, EP0_B, 8'h25, 8'h05,
        8'h7A, 8'h12, 8'h01, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
        // configuration, interface and two endpoints
        8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h03, 8'h02, 8'h20, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
        // other speed configuration
        8'h09, 8'h07, 8'h09, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
        // debug descriptor
        8'h04, 8'h0A, 8'h82, 8'h03,
        // device qualifier
        8'h0A, 8'h06, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, EP0_B, 8'h01, 8'h00,
        // language list
        8'h04, 8'h03, 8'h09, 8'h04,
        // manufacturer string
        8'h1A, 8'h03, 8'h4D, 8'h00, 8'h61, 8'h00, 8'h6E, 8'h00, 8'h75, 8'h00,
        8'h66, 8'h00, 8'h61, 8'h00, 8'h63, 8'h00, 8'h74, 8'h00, 8'h75, 8'h00,
        8'h72, 8'h00, 8'h65, 8'h00, 8'h72, 8'h00,
        // product string
        8'h28, 8'h03, 8'h55, 8'h00, 8'h53, 8'h00, 8'h42, 8'h00, 8'h20, 8'h00,
        8'h32, 8'h00, 8'h2E, 8'h00, 8'h30, 8'h00, 8'h20, 8'h00, 8'h44, 8'h00,
        8'h65, 8'h00, 8'h62, 8'h00, 8'h75, 8'h00, 8'h67, 8'h00, 8'h20, 8'h00,
        8'h43, 8'h00, 8'h61, 8'h00, 8'h62, 8'h00, 8'h6C, 8'h00, 8'h65, 8'h00,
        // serial number string
        8'h08, 8'h03, 8'h30, 8'h00, 8'h30, 8'h00, 8'h32, 8'h00
    };

    localparam t_dir_entry DIR_TABLE [0:DIR_COUNT-1] = '{
        '{16'h0100, 16'h0000, 8'd0,   8'd18},
        '{16'h0200, 16'h0000, 8'd18,  8'd32},
        '{16'h0700, 16'h0000, 8'd50,  8'd9},
        '{16'h0A00, 16'h0000, 8'd59,  8'd4},
        '{16'h0600, 16'h0000, 8'd63,  8'd10},
        '{16'h0300, 16'h0000, 8'd73,  8'd4},
        '{16'h0301, 16'h0409, 8'd77,  8'd26},
        '{16'h0302, 16'h0409, 8'd103, 8'd40},
        '{16'h0303, 16'h0409, 8'd143, 8'd8}
    };

    // Bytes past the end of the table or of the ROM window read as zero.
    function automatic logic [7:0] rom_byte(input logic [7:0] addr);
        logic [7:0] b;
        b = 8'h00;
        if ((int'(addr) < DESC_BYTES) && (int'(addr) < ROM_BYTES)) begin
            b = DESC_ROM[addr];
        end
        return b;
    endfunction

endpackage

[rtl/usb_control_request_responder.sv]
// Top level of the endpoint-zero control request responder.
// Depends on ucrr_pkg for the word types, request codes and descriptor table.
`timescale 1ns / 1ps

// The block takes one event word on the input channel (i_in_valid, o_in_ready,
// i_in) and answers with one or more result words on the output channel
// (o_out_valid, i_out_ready, o_out). The last result of each event carries
// the last flag, and every result carries the device state as it stands
// after the event.
//
// Events are handled one at a time by a small sequencer. An accepted word is
// decoded in the cycle after acceptance. A bus reset, start-of-frame tick or
// transmit-byte note then gives its single result, which the reply state puts
// into the output register; the input stays blocked until that result is loaded.
// A descriptor request walks the nine-entry directory through one shared
// compare, one entry per cycle, and then streams the descriptor bytes one per
// cycle from the constant table while the output register has room; the
// longest answer is the 40-byte product string found at the eighth entry.
// The input is ready only while the sequencer is idle.
//
// All results go through a single output register. When the receiver stalls,
// the sequencer holds until the register drains, and no result is lost.
// Synchronous reset returns the address, configuration, halt bits, flush
// countdown and lamp to zero and leaves the block idle with no result pending.
module usb_control_request_responder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ucrr_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ucrr_pkg::t_out_item o_out
);

    ucrr_pkg::t_state r_state, n_state;
    ucrr_pkg::t_in_item r_req;

    // Device state.
    logic [7:0]                         r_cfg, n_cfg;
    logic [6:0]                         r_addr, n_addr;
    logic [ucrr_pkg::NUM_ENDPOINTS-1:0] r_halt, n_halt;
    logic [2:0]                         r_fcnt, n_fcnt;
    logic                               r_lamp, n_lamp;
    logic                               r_flush, n_flush;

    // Sequencer working registers.
    logic [ucrr_pkg::DIR_IW-1:0] r_dir_idx, n_dir_idx;
    logic [7:0]                  r_pos, n_pos;
    logic [7:0]                  r_len, n_len;
    logic [ucrr_pkg::PKT_W-1:0]  r_pkt, n_pkt;
    logic [ucrr_pkg::RES_W-1:0]  r_sent, n_sent;
    ucrr_pkg::t_kind             r_rkind, n_rkind;
    logic [7:0]                  r_rbyte, n_rbyte;
    logic                        r_two, n_two;

    // Output register.
    ucrr_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_load;
    logic                 w_is_search;
    ucrr_pkg::t_dir_entry w_dir;
    logic                 w_dir_hit;
    logic                 w_dir_end;
    logic [7:0]           w_len;
    logic [ucrr_pkg::PKT_W-1:0] w_pkt_next;
    logic [ucrr_pkg::RES_W-1:0] w_sent_next;
    logic                 w_final_byte;
    logic                 w_zlp;
    logic [6:0]           w_ep;
    logic                 w_ep_ok;
    logic                 w_halt_sel;
    logic [ucrr_pkg::NUM_ENDPOINTS-1:0] w_ep_mask;

    assign o_in_ready  = (r_state == ucrr_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_is_search = (r_req.op == ucrr_pkg::OP_SETUP)
                      && (r_req.request == ucrr_pkg::REQ_GET_DESCRIPTOR);

    // Shared directory compare: one entry per cycle.
    assign w_dir     = ucrr_pkg::DIR_TABLE[r_dir_idx];
    assign w_dir_hit = (w_dir.sel_value == r_req.value) && (w_dir.sel_index == r_req.index);
    assign w_dir_end = (r_dir_idx == ucrr_pkg::DIR_IW'(ucrr_pkg::DIR_COUNT - 1));
    assign w_len     = (r_req.length < {8'd0, w_dir.size}) ? r_req.length[7:0] : w_dir.size;

    // Packet position wraps at the endpoint-zero packet size; a transfer that
    // ends on a packet boundary gets a trailing zero-length packet unless the
    // result budget is used up.
    assign w_pkt_next   = (r_pkt == ucrr_pkg::PKT_W'(ucrr_pkg::EP0_PACKET_BYTES - 1))
                        ? '0 : r_pkt + 1'b1;
    assign w_sent_next  = r_sent + 1'b1;
    assign w_final_byte = (r_len == 8'd1);
    assign w_zlp        = (w_pkt_next == '0)
                       && (w_sent_next != ucrr_pkg::RES_W'(ucrr_pkg::MAX_RESULTS));

    // Endpoint number from wIndex and its halt bit.
    assign w_ep = r_req.index[6:0];
    always_comb begin
        w_ep_ok    = 1'b0;
        w_halt_sel = 1'b0;
        w_ep_mask  = '0;
        for (int e = 0; e < ucrr_pkg::NUM_ENDPOINTS; e++) begin
            if (w_ep == 7'(e + 1)) begin
                w_ep_ok      = 1'b1;
                w_halt_sel   = r_halt[e];
                w_ep_mask[e] = 1'b1;
            end
        end
    end

    assign w_load = w_slot_free && ((r_state == ucrr_pkg::S_DATA)
                                 || (r_state == ucrr_pkg::S_ZLP)
                                 || (r_state == ucrr_pkg::S_REPLY));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ucrr_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ucrr_pkg::S_DECODE;
                end
            end
            ucrr_pkg::S_DECODE: begin
                n_state = w_is_search ? ucrr_pkg::S_SEARCH : ucrr_pkg::S_REPLY;
            end
            ucrr_pkg::S_SEARCH: begin
                if (w_dir_hit) begin
                    n_state = (w_len == 8'd0) ? ucrr_pkg::S_ZLP : ucrr_pkg::S_DATA;
                end else if (w_dir_end) begin
                    n_state = ucrr_pkg::S_REPLY;
                end
            end
            ucrr_pkg::S_DATA: begin
                if (w_load && w_final_byte) begin
                    n_state = w_zlp ? ucrr_pkg::S_ZLP : ucrr_pkg::S_IDLE;
                end
            end
            ucrr_pkg::S_ZLP: begin
                if (w_load) begin
                    n_state = ucrr_pkg::S_IDLE;
                end
            end
            ucrr_pkg::S_REPLY: begin
                if (w_load && !r_two) begin
                    n_state = ucrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ucrr_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and result words.
    always_comb begin
        n_cfg     = r_cfg;
        n_addr    = r_addr;
        n_halt    = r_halt;
        n_fcnt    = r_fcnt;
        n_lamp    = r_lamp;
        n_flush   = r_flush;
        n_dir_idx = r_dir_idx;
        n_pos     = r_pos;
        n_len     = r_len;
        n_pkt     = r_pkt;
        n_sent    = r_sent;
        n_rkind   = r_rkind;
        n_rbyte   = r_rbyte;
        n_two     = r_two;

        n_out                = r_out;
        n_out.configuration  = r_cfg;
        n_out.device_address = r_addr;
        n_out.led            = r_lamp;
        n_out.flush          = r_flush;

        unique case (r_state)
            ucrr_pkg::S_IDLE: begin
                n_flush   = 1'b0;
                n_dir_idx = '0;
                n_sent    = '0;
                n_pkt     = '0;
            end
            ucrr_pkg::S_DECODE: begin
                n_rkind = ucrr_pkg::K_STALL;
                n_rbyte = 8'h00;
                n_two   = 1'b0;
                if (r_req.op == ucrr_pkg::OP_SETUP) begin
                    if (r_req.request == ucrr_pkg::REQ_GET_DESCRIPTOR) begin
                        // Directory search follows; a miss leaves the stall set.
                    end else if (r_req.request == ucrr_pkg::REQ_SET_ADDRESS) begin
                        n_addr  = r_req.value[6:0];
                        n_rkind = ucrr_pkg::K_ZLP;
                    end else if ((r_req.request == ucrr_pkg::REQ_SET_FEATURE)
                              && (r_req.request_type == ucrr_pkg::RT_STD_DEVICE_OUT)
                              && (r_req.value == ucrr_pkg::FEAT_DEBUG_MODE)) begin
                        n_cfg   = 8'd1;
                        n_lamp  = 1'b1;
                        n_halt  = '0;
                        n_rkind = ucrr_pkg::K_ZLP;
                    end else if ((r_req.request == ucrr_pkg::REQ_SET_CONFIG)
                              && (r_req.request_type == ucrr_pkg::RT_STD_DEVICE_OUT)) begin
                        n_cfg   = r_req.value[7:0];
                        n_halt  = '0;
                        n_rkind = ucrr_pkg::K_ZLP;
                    end else if ((r_req.request == ucrr_pkg::REQ_GET_CONFIG)
                              && (r_req.request_type == ucrr_pkg::RT_STD_DEVICE_IN)) begin
                        n_rkind = ucrr_pkg::K_DATA;
                        n_rbyte = r_cfg;
                    end else if (r_req.request == ucrr_pkg::REQ_GET_STATUS) begin
                        n_rkind = ucrr_pkg::K_DATA;
                        n_rbyte = {7'd0, (r_req.request_type == ucrr_pkg::RT_STD_ENDPT_IN)
                                         && w_halt_sel};
                        n_two   = 1'b1;
                    end else if (((r_req.request == ucrr_pkg::REQ_CLEAR_FEATURE)
                               || (r_req.request == ucrr_pkg::REQ_SET_FEATURE))
                              && (r_req.request_type == ucrr_pkg::RT_STD_ENDPT_OUT)
                              && (r_req.value == 16'd0) && w_ep_ok) begin
                        if (r_req.request == ucrr_pkg::REQ_SET_FEATURE) begin
                            n_halt = r_halt | w_ep_mask;
                        end else begin
                            n_halt = r_halt & ~w_ep_mask;
                        end
                        n_rkind = ucrr_pkg::K_ZLP;
                    end else if (r_req.index == 16'd0) begin
                        // Interface fallback answers with a single zero byte.
                        n_rkind = ucrr_pkg::K_DATA;
                    end
                end else begin
                    n_rkind = ucrr_pkg::K_NONE;
                    if (r_req.op == ucrr_pkg::OP_BUS_RESET) begin
                        n_cfg  = 8'd0;
                        n_addr = 7'd0;
                        n_lamp = 1'b0;
                        n_halt = '0;
                    end else if (r_req.op == ucrr_pkg::OP_SOF) begin
                        if ((r_cfg != 8'd0) && (r_fcnt != 3'd0)) begin
                            n_fcnt  = r_fcnt - 3'd1;
                            n_flush = (r_fcnt == 3'd1);
                        end
                    end else if (r_cfg != 8'd0) begin
                        n_fcnt = 3'(ucrr_pkg::FLUSH_TICKS);
                    end
                end
            end
            ucrr_pkg::S_SEARCH: begin
                n_dir_idx = r_dir_idx + 1'b1;
                n_pos     = w_dir.offset;
                n_len     = w_len;
            end
            ucrr_pkg::S_DATA: begin
                n_out.kind      = ucrr_pkg::K_DATA;
                n_out.data_byte = ucrr_pkg::rom_byte(r_pos);
                n_out.last      = w_final_byte && !w_zlp;
                if (w_load) begin
                    n_pos  = r_pos + 8'd1;
                    n_len  = r_len - 8'd1;
                    n_pkt  = w_pkt_next;
                    n_sent = w_sent_next;
                end
            end
            ucrr_pkg::S_ZLP: begin
                n_out.kind      = ucrr_pkg::K_ZLP;
                n_out.data_byte = 8'h00;
                n_out.last      = 1'b1;
            end
            ucrr_pkg::S_REPLY: begin
                n_out.kind      = r_rkind;
                n_out.data_byte = r_rbyte;
                n_out.last      = !r_two;
                if (w_load) begin
                    // The second status byte is always zero.
                    n_rkind = ucrr_pkg::K_DATA;
                    n_rbyte = 8'h00;
                    n_two   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ucrr_pkg::S_IDLE;
            r_cfg       <= 8'd0;
            r_addr      <= 7'd0;
            r_halt      <= '0;
            r_fcnt      <= 3'd0;
            r_lamp      <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_addr  <= n_addr;
            r_halt  <= n_halt;
            r_fcnt  <= n_fcnt;
            r_lamp  <= n_lamp;
            r_flush <= n_flush;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        if (w_load) begin
            r_out <= n_out;
        end
        r_dir_idx <= n_dir_idx;
        r_pos     <= n_pos;
        r_len     <= n_len;
        r_pkt     <= n_pkt;
        r_sent    <= n_sent;
        r_rkind   <= n_rkind;
        r_rbyte   <= n_rbyte;
        r_two     <= n_two;
    end

    // The result budget of one event is never exceeded.
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sent <= ucrr_pkg::RES_W'(ucrr_pkg::MAX_RESULTS)))
        else $error("result budget exceeded");

    // Loading a word flagged last returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out.last) |=> (r_state == ucrr_pkg::S_IDLE))
        else $error("sequencer busy after last result");

    // A flush pulse only rides on a no-response result.
    a_flush_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.flush) |-> (o_out.kind == ucrr_pkg::K_NONE))
        else $error("flush on a bus response");

    // Byte streaming never runs with nothing left to send.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ucrr_pkg::S_DATA) |-> (r_len != 8'd0))
        else $error("data state with zero length");

endmodule
